FILE: hw/rtl/sbg_pkg.sv
// shared types, constants and key compare functions of the glyph batch sorter
`default_nettype none

package sbg_pkg;

    // vertices written per glyph
    localparam logic [8:0] VERTS_PER_GLYPH = 9'd6;

    // sort mode register codes, code 3 sorts as texture ascending
    typedef enum logic [1:0] {
        MODE_DEPTH_ASC  = 2'd0,
        MODE_DEPTH_DESC = 2'd1,
        MODE_TEX_ASC    = 2'd2
    } t_sort_mode;

    localparam t_sort_mode SORT_MODE_RESET = MODE_TEX_ASC;

    // control states of the top level
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    // what every cell of the row does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_EMIT
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        t_sort_mode mode;
    } t_cell_cmd;

    // sort keys of one glyph
    typedef struct packed {
        logic [31:0]        tex;
        logic signed [31:0] depth;
    } t_glyph_key;

    // strict key order under a mode
    function automatic logic key_less(input t_glyph_key a, input t_glyph_key b,
                                      input t_sort_mode mode);
        logic res;
        case (mode)
            MODE_DEPTH_ASC:  res = (a.depth < b.depth);
            MODE_DEPTH_DESC: res = (a.depth > b.depth);
            default:         res = (a.tex < b.tex);
        endcase
        return res;
    endfunction

    // key equality under a mode
    function automatic logic key_equal(input t_glyph_key a, input t_glyph_key b,
                                       input t_sort_mode mode);
        logic res;
        case (mode)
            MODE_DEPTH_ASC:  res = (a.depth == b.depth);
            MODE_DEPTH_DESC: res = (a.depth == b.depth);
            default:         res = (a.tex == b.tex);
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sbg_cell.sv
// one cell of the glyph row: holds a glyph, shifts, and compare-exchanges with its right neighbor
`default_nettype none

module sbg_cell import sbg_pkg::*; #(
    parameter int SLOT_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic              i_pair_lo,
    input  wire logic              i_left_valid,
    input  wire t_glyph_key        i_left_key,
    input  wire logic [SLOT_W-1:0] i_left_slot,
    input  wire logic              i_swap_left,
    input  wire logic              i_right_valid,
    input  wire t_glyph_key        i_right_key,
    input  wire logic [SLOT_W-1:0] i_right_slot,
    output logic                   o_valid,
    output t_glyph_key             o_key,
    output logic [SLOT_W-1:0]      o_slot,
    output logic                   o_swap
);

    logic              r_valid;
    t_glyph_key        r_key;
    logic [SLOT_W-1:0] r_slot;
    logic              n_valid;
    t_glyph_key        n_key;
    logic [SLOT_W-1:0] n_slot;
    logic              w_right_first;

    // right glyph goes before this one: key order, load slot breaks ties
    always_comb begin
        w_right_first = key_less(i_right_key, r_key, i_cmd.mode) ||
                        (key_equal(i_right_key, r_key, i_cmd.mode) &&
                         (i_right_slot < r_slot));
    end

    assign o_swap = (i_cmd.op == OP_SORT) && i_pair_lo && r_valid && i_right_valid &&
                    w_right_first;

    // next cell contents
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_slot  = r_slot;
        case (i_cmd.op)
            OP_LOAD: begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
                n_slot  = i_left_slot;
            end
            OP_SORT: begin
                if (o_swap) begin
                    n_key  = i_right_key;
                    n_slot = i_right_slot;
                end else if (i_swap_left) begin
                    n_key  = i_left_key;
                    n_slot = i_left_slot;
                end
            end
            OP_EMIT: begin
                n_valid = i_right_valid;
                n_key   = i_right_key;
                n_slot  = i_right_slot;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // valid flag is control, glyph data is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_slot  = r_slot;

endmodule

`default_nettype wire

FILE: hw/rtl/stable_sort_batch_grouper.sv
// top level of the glyph batch sorter: cell row, frame control and result outputs
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  glyph   | in        | i_valid / o_stall            | i_texture_id, i_glyph_depth,
//          |           |                              | i_last_glyph
//  result  | out       | o_valid / i_stall            | o_glyph_slot, o_glyph_texture,
//          |           |                              | o_batch_start, o_vertex_offset,
//          |           |                              | o_overflow, o_last_result
//  config  | in        | i_cfg_we                     | i_cfg_wdata (sort mode)
//
// Glyphs load at one item per cycle, shifting into a row of MAX_GLYPHS cells.
// After the last item the row runs one odd-even compare-exchange pass per cycle,
// N passes for N stored glyphs, then shifts out one result per cycle from cell 0
// while i_stall is low. The glyph input is stalled from the last item until
// the final result is taken. Synchronous active-low reset empties the row and
// sets the sort mode to texture ascending. A stalled result holds its payload.
`default_nettype none

module stable_sort_batch_grouper import sbg_pkg::*; #(
    parameter int MAX_GLYPHS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [31:0]        i_texture_id,
    input  wire logic signed [31:0] i_glyph_depth,
    input  wire logic               i_last_glyph,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [5:0]              o_glyph_slot,
    output logic [31:0]             o_glyph_texture,
    output logic                    o_batch_start,
    output logic [8:0]              o_vertex_offset,
    output logic                    o_overflow,
    output logic                    o_last_result,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_wdata
);

    localparam int SLOT_W = $clog2(MAX_GLYPHS);
    localparam int CNT_W  = $clog2(MAX_GLYPHS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GLYPHS);

    t_state           r_state;
    t_state           n_state;
    t_sort_mode       r_mode;
    t_sort_mode       r_frame_mode;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_pass;
    logic             r_dropped;
    logic             r_first;
    logic [8:0]       r_vert;
    logic [31:0]      r_prev_tex;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_full;
    logic             w_sort_done;
    t_cell_cmd        w_cmd;

    logic [MAX_GLYPHS-1:0]   w_cell_valid;
    t_glyph_key              w_cell_key  [MAX_GLYPHS];
    logic [SLOT_W-1:0]       w_cell_slot [MAX_GLYPHS];
    logic [MAX_GLYPHS-1:0]   w_swap;
    logic [MAX_GLYPHS-1:0]   w_pair_lo;
    logic [SLOT_W+5:0]       w_slot_ext;
    t_glyph_key              w_in_key;

    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = o_valid && !i_stall;
    assign w_full      = (r_count >= CNT_MAX);
    assign w_sort_done = (r_pass >= r_count);
    assign w_in_key    = '{tex: i_texture_id, depth: i_glyph_depth};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_last_glyph) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (w_sort_done) begin
                    n_state = (r_count == '0) ? ST_LOAD : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && o_last_result) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // handshakes and row command
    always_comb begin
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        w_cmd.op   = OP_HOLD;
        w_cmd.mode = r_frame_mode;
        case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
                if (i_valid && !w_full) begin
                    w_cmd.op = OP_LOAD;
                end
            end
            ST_SORT: begin
                if (!w_sort_done) begin
                    w_cmd.op = OP_SORT;
                end
            end
            ST_EMIT: begin
                o_valid = (r_count != '0);
                if (o_valid && !i_stall) begin
                    w_cmd.op = OP_EMIT;
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // state, mode register and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_mode       <= SORT_MODE_RESET;
            r_frame_mode <= SORT_MODE_RESET;
            r_count      <= '0;
            r_pass       <= '0;
            r_dropped    <= 1'b0;
            r_first      <= 1'b1;
            r_vert       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= t_sort_mode'(i_cfg_wdata);
            end
            case (r_state)
                ST_LOAD: begin
                    r_pass  <= '0;
                    r_first <= 1'b1;
                    r_vert  <= '0;
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_last_glyph) begin
                            r_frame_mode <= r_mode;
                        end
                    end
                end
                ST_SORT: begin
                    if (!w_sort_done) begin
                        r_pass <= r_pass + 1'b1;
                    end else if (r_count == '0) begin
                        r_dropped <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        r_count <= r_count - 1'b1;
                        r_first <= 1'b0;
                        r_vert  <= r_vert + VERTS_PER_GLYPH;
                        if (o_last_result) begin
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_pass <= '0;
                end
            endcase
        end
    end

    // texture of the previously emitted glyph
    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_prev_tex <= w_cell_key[0].tex;
        end
    end

    // row of cells, cell 0 takes new glyphs and gives results
    genvar gi;
    generate
        for (gi = 0; gi < MAX_GLYPHS; gi++) begin : g_cell
            logic              w_lv;
            t_glyph_key        w_lk;
            logic [SLOT_W-1:0] w_ls;
            logic              w_lsw;
            logic              w_rv;
            t_glyph_key        w_rk;
            logic [SLOT_W-1:0] w_rs;

            assign w_pair_lo[gi] = (r_pass[0] == 1'(gi % 2));

            if (gi == 0) begin : g_head
                assign w_lv  = 1'b1;
                assign w_lk  = w_in_key;
                assign w_ls  = r_count[SLOT_W-1:0];
                assign w_lsw = 1'b0;
            end else begin : g_mid
                assign w_lv  = w_cell_valid[gi-1];
                assign w_lk  = w_cell_key[gi-1];
                assign w_ls  = w_cell_slot[gi-1];
                assign w_lsw = w_swap[gi-1];
            end

            if (gi == MAX_GLYPHS - 1) begin : g_tail
                assign w_rv = 1'b0;
                assign w_rk = '0;
                assign w_rs = '0;
            end else begin : g_body
                assign w_rv = w_cell_valid[gi+1];
                assign w_rk = w_cell_key[gi+1];
                assign w_rs = w_cell_slot[gi+1];
            end

            sbg_cell #(
                .SLOT_W(SLOT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_pair_lo    (w_pair_lo[gi]),
                .i_left_valid (w_lv),
                .i_left_key   (w_lk),
                .i_left_slot  (w_ls),
                .i_swap_left  (w_lsw),
                .i_right_valid(w_rv),
                .i_right_key  (w_rk),
                .i_right_slot (w_rs),
                .o_valid      (w_cell_valid[gi]),
                .o_key        (w_cell_key[gi]),
                .o_slot       (w_cell_slot[gi]),
                .o_swap       (w_swap[gi])
            );
        end
    endgenerate

    // result fields from cell 0 and the emit counters
    assign w_slot_ext      = {6'b0, w_cell_slot[0]};
    assign o_glyph_slot    = w_slot_ext[5:0];
    assign o_glyph_texture = w_cell_key[0].tex;
    assign o_batch_start   = r_first || (w_cell_key[0].tex != r_prev_tex);
    assign o_vertex_offset = r_vert;
    assign o_overflow      = r_dropped;
    assign o_last_result   = (r_count == CNT_W'(1));

    // no glyph is taken while results are pending
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("glyph input open while results pending");

    // the number of occupied cells matches the glyph count while loading
    a_count_matches_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ($countones(w_cell_valid) == int'(r_count)))
        else $error("cell row occupancy differs from glyph count");

    // the final result returns the block to loading with an empty row
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_result) |=>
            ((r_state == ST_LOAD) && (r_count == '0) && !r_dropped))
        else $error("frame did not end after final result");

    // a result is presented only from an occupied head cell
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_cell_valid[0])
        else $error("result shown from empty head cell");

endmodule

`default_nettype wire
